// ===== hdl/mac_pkg.sv =====
// Package for the multichannel compressor: widths, register indexes, tables.
// Used by every module in hdl/.
package mac_pkg;
    localparam int SampleBits = 16;
    localparam int NumChannels = 8;
    localparam int ChanBits = 3;
    localparam int EnvBits = 25;
    localparam int CfgIdxBits = 2;
    localparam logic [CfgIdxBits-1:0] CfgThreshold = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgRatio = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgMakeup = 2'd2;
    localparam logic [16:0] AttackQ16 = 17'd6554;
    localparam logic [16:0] ReleaseQ16 = 17'd655;

    function automatic logic [16:0] log2_tab(input logic [4:0] i);
        logic [16:0] v;
        begin
            case (i)
                5'd0: v = 17'd0;      5'd1: v = 17'd5732;   5'd2: v = 17'd11136;
                5'd3: v = 17'd16248;  5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
                5'd6: v = 17'd30109;  5'd7: v = 17'd34312;  5'd8: v = 17'd38336;
                5'd9: v = 17'd42196;  5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
                5'd12: v = 17'd52911; 5'd13: v = 17'd56229; 5'd14: v = 17'd59434;
                5'd15: v = 17'd62534; default: v = 17'd65536;
            endcase
            return v;
        end
    endfunction

    function automatic logic [17:0] exp2_tab(input logic [4:0] i);
        logic [17:0] v;
        begin
            case (i)
                5'd0: v = 18'd65536;   5'd1: v = 18'd68438;   5'd2: v = 18'd71468;
                5'd3: v = 18'd74632;   5'd4: v = 18'd77936;   5'd5: v = 18'd81386;
                5'd6: v = 18'd84990;   5'd7: v = 18'd88752;   5'd8: v = 18'd92682;
                5'd9: v = 18'd96785;   5'd10: v = 18'd101070; 5'd11: v = 18'd105545;
                5'd12: v = 18'd110218; 5'd13: v = 18'd115098; 5'd14: v = 18'd120193;
                5'd15: v = 18'd125515; default: v = 18'd131072;
            endcase
            return v;
        end
    endfunction
endpackage

// ===== hdl/mac_mul.sv =====
// Shared 32x32 multiplier with registered product for the compressor sequencer.
// Depends on mac_pkg.
module mac_mul
    import mac_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

// ===== hdl/mac_div.sv =====
// Restoring divider, one quotient bit per cycle, 36-bit dividend, 13-bit divisor.
// Depends on mac_pkg.
module mac_div
    import mac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_num,
    input  logic [12:0] i_den,
    output logic        o_done,
    output logic [35:0] o_quo
);
    logic [35:0] r_q;
    logic [13:0] r_rem;
    logic [12:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [13:0] w_sh;
    assign w_sh = {r_rem[12:0], r_q[35]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'd36;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= {r_q[34:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[34:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ===== hdl/multichannel_audio_compressor.sv =====
// Multichannel compressor top level: sequencer, envelope store, config registers.
// Depends on mac_pkg, mac_mul, mac_div.
//
// Usage: an input word (sample, channel) is taken when i_valid is high and
// o_stall is low. The block then works on that word alone, driving o_stall
// high, through a sequencer that feeds one shared 32x32 multiplier and a
// one-bit-a-cycle divider. A word whose envelope is above threshold goes
// through the envelope update, the logs of envelope and threshold, the ratio
// multiply, the 36-step divider, exp2 and two gain multiplies; below threshold
// the log, divide and exp2 steps are skipped; bypass sends the word straight out.
// The result is held in an output register with o_valid until i_stall is
// low; the next input word is taken while the result waits. If the register
// is still held when a new result is ready, the sequencer waits in its last step.
// Configuration writes (i_cfg_valid, o_cfg_ready) go to registers 0..2:
// threshold, ratio, makeup gain; write only while idle.
// Synchronous reset clears all envelopes to zero and loads register defaults.
module multichannel_audio_compressor
    import mac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [15:0]    i_sample_in,
    input  logic [2:0]            i_channel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_sample_out,
    output logic [2:0]            o_channel_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIdxBits-1:0] i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_ENV_M, S_ENV_W, S_LOGE, S_LOGE_M, S_LOGE_W, S_LOGT, S_LOGT_M,
        S_LOGT_W, S_YMUL, S_YMUL_W, S_DIV, S_DIV_W, S_EXP_M, S_EXP_W, S_G1,
        S_G1_W, S_G2, S_G2_W, S_OUT, S_HOLD
    } t_state;

    t_state r_state;
    logic [15:0] r_thr, r_mk;
    logic [12:0] r_ratio;
    logic [EnvBits-1:0] r_env [NumChannels];
    logic [15:0] r_raw;
    logic [2:0]  r_ch;
    logic        r_neg;
    logic [16:0] r_mag;
    logic [EnvBits-1:0] r_a, r_e;
    logic        r_rise;
    logic [31:0] r_le, r_l, r_y;
    logic [35:0] r_yp;
    logic [4:0]  r_p;
    logic [4:0]  r_idx;
    logic [16:0] r_gq;
    logic [63:0] r_acc;
    logic        r_ovalid;
    logic [15:0] r_out;
    logic [2:0]  r_cho;
    logic [31:0] n_ma, n_mb;
    logic [63:0] w_p;
    logic        n_dstart;
    logic        w_ddone;
    logic [35:0] w_quo;

    mac_mul u_mul (.i_clk(i_clk), .i_a(n_ma), .i_b(n_mb), .o_p(w_p));
    mac_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_dstart),
        .i_num(r_yp), .i_den(r_ratio), .o_done(w_ddone), .o_quo(w_quo));

    logic        w_take;
    logic [15:0] w_thr_c;
    logic [EnvBits-1:0] w_thr;
    logic [EnvBits-1:0] w_logv;
    logic [4:0]  w_lp;
    logic [23:0] w_fm;
    logic [16:0] w_ld;
    logic [16:0] w_mag0;
    logic [EnvBits-1:0] w_diff;
    logic [15:0] w_u;
    logic [17:0] w_ed;
    logic [4:0]  w_n;
    logic [16:0] w_r;

    assign w_take = i_valid && !o_stall;
    assign w_thr_c = (r_thr == 16'd0) ? 16'd1 : (r_thr > 16'd32768 ? 16'd32768 : r_thr);
    assign w_thr = {w_thr_c, 9'd0};
    assign w_logv = (r_state == S_LOGE || r_state == S_LOGE_M) ? r_e : w_thr;
    assign w_mag0 = i_sample_in[15] ? 17'({1'b0, ~i_sample_in} + 17'd1)
                                    : {1'b0, i_sample_in};
    assign w_diff = r_rise ? (r_a - r_e) : (r_e - r_a);
    assign w_u = 16'(17'h10000 - {1'b0, r_y[15:0]});
    assign w_ed = exp2_tab({1'b0, w_u[15:12]} + 5'd1) - exp2_tab({1'b0, w_u[15:12]});
    assign w_n = r_y[20:16];
    assign w_r = (r_acc[40:24] > (r_neg ? 17'h8000 : 17'h7FFF)) || (|r_acc[63:41])
                 ? (r_neg ? 17'h8000 : 17'h7FFF) : r_acc[40:24];

    always_comb begin
        w_lp = 5'd0;
        for (int k = 0; k < EnvBits; k++) begin
            if (w_logv[k]) w_lp = 5'(k);
        end
    end
    assign w_fm = 24'((w_logv << (5'd24 - w_lp)));
    assign w_ld = log2_tab({1'b0, w_fm[23:20]} + 5'd1) - log2_tab({1'b0, w_fm[23:20]});

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        n_dstart = 1'b0;
        case (r_state)
            S_ENV_M: begin
                n_ma = 32'(w_diff);
                n_mb = r_rise ? 32'(AttackQ16) : 32'(ReleaseQ16);
            end
            S_LOGE_M, S_LOGT_M: begin
                n_ma = 32'(w_ld);
                n_mb = 32'(w_fm[19:0]);
            end
            S_YMUL: begin
                n_ma = r_l;
                n_mb = 32'(r_ratio - 13'd256);
            end
            S_EXP_M: begin
                n_ma = 32'(w_ed);
                n_mb = 32'(w_u[11:0]);
            end
            S_G1: begin
                n_ma = 32'(r_mag);
                n_mb = 32'(r_gq);
            end
            S_G2: begin
                n_ma = r_acc[31:0];
                n_mb = 32'(r_mk);
            end
            S_DIV: n_dstart = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_thr    <= 16'd32768;
            r_ratio  <= 13'd256;
            r_mk     <= 16'd4096;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NumChannels; k++) r_env[k] <= '0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_OUT && r_state != S_HOLD)
                r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CfgThreshold: r_thr <= i_cfg_data;
                    CfgRatio:     r_ratio <= i_cfg_data[12:0];
                    CfgMakeup:    r_mk <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_raw <= i_sample_in;
                        r_ch  <= i_channel;
                        r_neg <= i_sample_in[15];
                        r_mag <= w_mag0;
                        r_a   <= {w_mag0[15:0], 9'd0};
                        r_e   <= r_env[i_channel];
                        r_rise <= {w_mag0[15:0], 9'd0} > r_env[i_channel];
                        r_state <= (r_ratio <= 13'd256) ? S_HOLD : S_ENV_M;
                    end
                end
                S_ENV_M: r_state <= S_ENV_W;
                S_ENV_W: begin
                    r_e <= r_rise ? r_e + 25'((w_p + 64'd32768) >> 16)
                                  : r_e - 25'((w_p + 64'd32768) >> 16);
                    r_env[r_ch] <= r_rise ? r_e + 25'((w_p + 64'd32768) >> 16)
                                          : r_e - 25'((w_p + 64'd32768) >> 16);
                    r_state <= S_LOGE;
                end
                S_LOGE: begin
                    if (r_e > w_thr) begin
                        r_p <= w_lp;
                        r_idx <= {1'b0, w_fm[23:20]};
                        r_state <= S_LOGE_M;
                    end else begin
                        r_gq <= 17'd4096;
                        r_state <= S_G1;
                    end
                end
                S_LOGE_M: r_state <= S_LOGE_W;
                S_LOGE_W: begin
                    r_le <= {11'd0, r_p, 16'd0} + 32'(log2_tab(r_idx))
                            + 32'((w_p + 64'd524288) >> 20);
                    r_state <= S_LOGT;
                end
                S_LOGT: begin
                    r_p <= w_lp;
                    r_idx <= {1'b0, w_fm[23:20]};
                    r_state <= S_LOGT_M;
                end
                S_LOGT_M: r_state <= S_LOGT_W;
                S_LOGT_W: begin
                    r_l <= (r_le > ({11'd0, r_p, 16'd0} + 32'(log2_tab(r_idx))
                            + 32'((w_p + 64'd524288) >> 20)))
                        ? r_le - ({11'd0, r_p, 16'd0} + 32'(log2_tab(r_idx))
                            + 32'((w_p + 64'd524288) >> 20)) : 32'd0;
                    r_state <= S_YMUL;
                end
                S_YMUL: r_state <= S_YMUL_W;
                S_YMUL_W: begin
                    r_yp <= w_p[35:0];
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DIV_W;
                S_DIV_W: begin
                    if (w_ddone) begin
                        r_y <= w_quo[31:0];
                        r_state <= S_EXP_M;
                    end
                end
                S_EXP_M: begin
                    r_idx <= {1'b0, w_u[15:12]};
                    r_state <= S_EXP_W;
                end
                S_EXP_W: begin
                    if (r_y[31:16] > 16'd30) begin
                        r_gq <= 17'((32'd0 + 8) >> 4);
                    end else if (r_y[15:0] == 16'd0) begin
                        r_gq <= 17'(((32'd65536 >> w_n) + 32'd8) >> 4);
                    end else begin
                        r_gq <= 17'((((32'(exp2_tab(r_idx)) + 32'((w_p + 64'd2048) >> 12))
                                >> (w_n + 5'd1)) + 32'd8) >> 4);
                    end
                    r_state <= S_G1;
                end
                S_G1: r_state <= S_G1_W;
                S_G1_W: begin
                    r_acc <= w_p;
                    r_state <= S_G2;
                end
                S_G2: r_state <= S_G2_W;
                S_G2_W: begin
                    r_acc <= w_p + 64'd8388608;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out <= r_neg ? 16'(17'h10000 - w_r) : w_r[15:0];
                        r_cho <= r_ch;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_HOLD: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out <= r_raw;
                        r_cho <= r_ch;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_sample_out = r_out;
    assign o_channel_out = r_cho;
endmodule

// ===== hdl/mac_checker.sv =====
// Port-level checker for the multichannel compressor, bound to the top level.
// Depends on mac_pkg.
module mac_checker
    import mac_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_sample_out,
    input logic [2:0]  o_channel_out,
    input logic        o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out) && $stable(o_channel_out))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accept");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_stall)
        else $error("config ready while busy");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind multichannel_audio_compressor mac_checker u_mac_checker (.*);
